>>> rtl/core/dcpec_pkg.sv
// Shared types, constants and the PEC byte-update function for the PEC frame checker.
package dcpec_pkg;

	localparam logic [15:0] PEC_POLY     = 16'h4599;
	localparam logic [15:0] PEC_SEED     = 16'd16;
	localparam logic [2:0]  HEADER_BYTES = 3'd4;
	localparam logic [2:0]  DATA_BYTES   = 3'd6;
	localparam logic [2:0]  POS_PEC_LOW  = 3'd7;
	localparam logic [5:0]  MAX_DEVICES  = 6'd32;
	localparam logic [5:0]  PASS_MAX     = 6'd63;
	localparam logic [5:0]  DEV_RESET    = 6'd1;

	// Kind of a request handed from the front part to the back part.
	localparam logic [1:0] KIND_DATA   = 2'd0;
	localparam logic [1:0] KIND_PEC_HI = 2'd1;
	localparam logic [1:0] KIND_PEC_LO = 2'd2;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       frame_start;
	} in_t;

	typedef struct packed {
		logic [4:0]  device_index;
		logic [15:0] word_first;
		logic [15:0] word_second;
		logic [15:0] word_third;
		logic        check_passed;
		logic [5:0]  passed_so_far;
		logic        last_device;
	} out_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] byte_val;
		logic [2:0] pos;
		logic [4:0] group;
		logic       last;
	} work_t;

	typedef struct packed {
		logic  valid;
		work_t item;
	} work_req_t;

	// Table-free 8-bit step of the CRC-15 remainder.
	function automatic logic [15:0] pec_update(input logic [15:0] rem, input logic [7:0] b);
		logic [15:0] r;
		r = {1'b0, rem[14:7] ^ b, 7'b0};
		for (int i = 0; i < 8; i++) begin
			if (r[14]) begin
				r = {r[14:0], 1'b0} ^ PEC_POLY;
			end else begin
				r = {r[14:0], 1'b0};
			end
		end
		return {rem[7:0], 8'b0} ^ r;
	endfunction

endpackage

>>> rtl/core/dcpec_front.sv
// Front part: frame tracking, header skip and byte classification.
module dcpec_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_stall,
	input  dcpec_pkg::in_t    in_data,
	input  logic              cfg_we,
	input  logic [5:0]        cfg_wdata,
	output dcpec_pkg::work_req_t push
);
	import dcpec_pkg::*;

	logic [5:0] dev_count_q;
	logic [2:0] header_q;
	logic [2:0] pos_q;
	logic [4:0] group_q;
	logic       done_q;
	logic       accept;
	logic       take;
	logic [5:0] limit;
	logic       last;

	assign accept = in_valid && !in_stall;

	always_comb begin
		if (dev_count_q == 6'd0) begin
			limit = 6'd1;
		end else if (dev_count_q > MAX_DEVICES) begin
			limit = MAX_DEVICES;
		end else begin
			limit = dev_count_q;
		end
	end

	assign last = ({1'b0, group_q} + 6'd1) >= limit;
	assign take = accept && !in_data.frame_start && !done_q && (header_q == 3'd0);

	always_comb begin
		push.valid         = take;
		push.item.byte_val = in_data.rx_byte;
		push.item.pos      = pos_q;
		push.item.group    = group_q;
		push.item.last     = last;
		if (pos_q < DATA_BYTES) begin
			push.item.kind = KIND_DATA;
		end else if (pos_q == POS_PEC_LOW) begin
			push.item.kind = KIND_PEC_LO;
		end else begin
			push.item.kind = KIND_PEC_HI;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_count_q <= DEV_RESET;
		end else if (cfg_we) begin
			dev_count_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q <= HEADER_BYTES;
			pos_q    <= 3'd0;
			group_q  <= 5'd0;
			done_q   <= 1'b1;
		end else if (accept) begin
			if (in_data.frame_start) begin
				// start byte is itself the first echo byte
				header_q <= HEADER_BYTES - 3'd1;
				pos_q    <= 3'd0;
				group_q  <= 5'd0;
				done_q   <= 1'b0;
			end else if (!done_q) begin
				if (header_q != 3'd0) begin
					header_q <= header_q - 3'd1;
				end else if (pos_q == POS_PEC_LOW) begin
					pos_q <= 3'd0;
					if (last) begin
						done_q <= 1'b1;
					end else begin
						group_q <= group_q + 5'd1;
					end
				end else begin
					pos_q <= pos_q + 3'd1;
				end
			end
		end
	end

endmodule

>>> rtl/core/dcpec_queue.sv
// Two-entry request queue between the front and back parts.
module dcpec_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dcpec_pkg::work_req_t push,
	input  logic                 pop,
	output dcpec_pkg::work_req_t head,
	output logic                 full
);
	import dcpec_pkg::*;

	work_t      entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_pop;

	assign full       = (count_q == 2'd2);
	assign head.valid = (count_q != 2'd0);
	assign head.item  = entry_q[rd_ptr_q];
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk) begin
		if (push.valid) begin
			entry_q[wr_ptr_q] <= push.item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push.valid, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> rtl/core/dcpec_back.sv
// Back part: CRC update, data capture, PEC compare and output register.
module dcpec_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dcpec_pkg::work_req_t head,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_stall,
	output dcpec_pkg::out_t      out_data
);
	import dcpec_pkg::*;

	logic [15:0] crc_q;
	logic [47:0] data_q;
	logic [7:0]  pec_hi_q;
	logic [5:0]  pass_q;
	logic        out_valid_q;
	out_t        out_q;
	logic        is_lo;
	logic        slot_free;
	logic        ok;
	logic [5:0]  pass_next;
	logic [15:0] crc_base;

	assign is_lo     = (head.item.kind == KIND_PEC_LO);
	assign slot_free = !out_valid_q || !out_stall;
	assign pop       = head.valid && (!is_lo || slot_free);

	assign crc_base  = (head.item.pos == 3'd0) ? PEC_SEED : crc_q;
	assign ok        = ({pec_hi_q, head.item.byte_val} == {crc_q[14:0], 1'b0});
	assign pass_next = (ok && (pass_q != PASS_MAX)) ? pass_q + 6'd1 : pass_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			unique case (head.item.kind)
				KIND_DATA: begin
					crc_q <= pec_update(crc_base, head.item.byte_val);
					for (int i = 0; i < 6; i++) begin
						if (head.item.pos == 3'(i)) begin
							data_q[i*8 +: 8] <= head.item.byte_val;
						end
					end
				end
				KIND_PEC_HI: begin
					pec_hi_q <= head.item.byte_val;
				end
				KIND_PEC_LO: begin
					out_q.device_index  <= head.item.group;
					out_q.word_first    <= data_q[15:0];
					out_q.word_second   <= data_q[31:16];
					out_q.word_third    <= data_q[47:32];
					out_q.check_passed  <= ok;
					out_q.passed_so_far <= pass_next;
					out_q.last_device   <= head.item.last;
				end
				default: begin
				end
			endcase
		end
	end

	// pass count restarts with the first data byte of a frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pass_q <= 6'd0;
		end else if (pop) begin
			if (head.item.kind == KIND_DATA && head.item.pos == 3'd0
					&& head.item.group == 5'd0) begin
				pass_q <= 6'd0;
			end else if (is_lo) begin
				pass_q <= pass_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && is_lo) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

>>> rtl/core/daisy_chain_pec_frame_checker_core.sv
// Checks the PEC of each device group in a daisy-chain read response and reports its data.
// Takes one byte per cycle while in_stall is low. The front part tracks the frame (four
// echo bytes skipped, then 8-byte groups) and hands each group byte as a request through a
// two-entry queue to the back part, which updates the CRC-15 (polynomial 0x4599, seed 16)
// one byte per cycle unless a second PEC byte waits on a held result, and on that byte
// loads the result register. A result may wait in that register while bytes keep flowing;
// input stall rises only when the queue is full behind a held result.
module daisy_chain_pec_frame_checker_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  dcpec_pkg::in_t   in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output dcpec_pkg::out_t  out_data,
	input  logic             cfg_we,
	input  logic [5:0]       cfg_wdata
);
	import dcpec_pkg::*;

	work_req_t push;
	work_req_t head;
	logic      pop;
	logic      full;

	assign in_stall = full;

	dcpec_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.push      (push)
	);

	dcpec_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.full   (full)
	);

	dcpec_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push.valid)
		else $error("request pushed into full queue");

	a_lo_pop_loads_result: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && head.valid && head.item.kind == KIND_PEC_LO) |=> out_valid)
		else $error("PEC request popped without a result");

	a_pass_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.passed_so_far <= {1'b0, out_data.device_index} + 6'd1))
		else $error("pass count exceeds groups seen");

endmodule
